>>> src/lbc_pkg.sv
// Shared types, constants and functions of the LBlock 64/80 cipher core.
// Holds the S-boxes, the round F function and one key schedule step.
// No dependencies; imported by lbc_round and lblock_cipher_64_80_core.
`default_nettype none

package lbc_pkg;

	// default number of Feistel rounds
	localparam int unsigned LBC_ROUNDS = 32;

	// S0..S7 for the round function, S8/S9 for the key schedule
	localparam logic [3:0] SBOX [10][16] = '{
		'{4'd14, 4'd9,  4'd15, 4'd0,  4'd13, 4'd4,  4'd10, 4'd11,
		  4'd1,  4'd2,  4'd8,  4'd3,  4'd7,  4'd6,  4'd12, 4'd5},
		'{4'd4,  4'd11, 4'd14, 4'd9,  4'd15, 4'd13, 4'd0,  4'd10,
		  4'd7,  4'd12, 4'd5,  4'd6,  4'd2,  4'd8,  4'd1,  4'd3},
		'{4'd1,  4'd14, 4'd7,  4'd12, 4'd15, 4'd13, 4'd0,  4'd6,
		  4'd11, 4'd5,  4'd9,  4'd3,  4'd2,  4'd4,  4'd8,  4'd10},
		'{4'd7,  4'd6,  4'd8,  4'd11, 4'd0,  4'd15, 4'd3,  4'd14,
		  4'd9,  4'd10, 4'd12, 4'd13, 4'd5,  4'd2,  4'd4,  4'd1},
		'{4'd14, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd12, 4'd13,
		  4'd1,  4'd8,  4'd4,  4'd9,  4'd11, 4'd10, 4'd6,  4'd3},
		'{4'd2,  4'd13, 4'd11, 4'd12, 4'd15, 4'd14, 4'd0,  4'd9,
		  4'd7,  4'd10, 4'd6,  4'd3,  4'd1,  4'd8,  4'd4,  4'd5},
		'{4'd11, 4'd9,  4'd4,  4'd14, 4'd0,  4'd15, 4'd10, 4'd13,
		  4'd6,  4'd12, 4'd5,  4'd7,  4'd3,  4'd8,  4'd1,  4'd2},
		'{4'd13, 4'd10, 4'd15, 4'd0,  4'd14, 4'd4,  4'd9,  4'd11,
		  4'd2,  4'd1,  4'd8,  4'd3,  4'd7,  4'd5,  4'd12, 4'd6},
		'{4'd8,  4'd7,  4'd14, 4'd5,  4'd15, 4'd13, 4'd0,  4'd6,
		  4'd11, 4'd12, 4'd9,  4'd10, 4'd2,  4'd4,  4'd1,  4'd3},
		'{4'd11, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd9,  4'd13,
		  4'd4,  4'd8,  4'd1,  4'd12, 4'd14, 4'd10, 4'd3,  4'd6}
	};

	// output nibble j of the permutation takes S-box output nibble PERM_SRC[j]
	localparam int unsigned PERM_SRC [8] = '{1, 3, 0, 2, 5, 7, 4, 6};

	// FSM states of the core
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_PREP,
		ST_ROUND
	} lbc_state_t;

	// configuration register indexes
	typedef enum logic {
		REG_KEY_LOW,
		REG_KEY_HIGH
	} lbc_reg_t;

	// round function: S-box layer then nibble permutation
	function automatic logic [31:0] lbc_f(input logic [31:0] x);
		logic [31:0] s;
		logic [31:0] p;
		for (int j = 0; j < 8; j++) begin
			s[4*j +: 4] = SBOX[j][x[4*j +: 4]];
		end
		for (int j = 0; j < 8; j++) begin
			p[4*j +: 4] = s[4*PERM_SRC[j] +: 4];
		end
		return p;
	endfunction

	// one key schedule step: rotl 29, S9/S8 on top byte, round index into 50..46
	function automatic logic [79:0] lbc_key_step(input logic [79:0] k, input logic [4:0] idx);
		logic [79:0] r;
		r = {k[50:0], k[79:51]};
		r[79:76] = SBOX[9][r[79:76]];
		r[75:72] = SBOX[8][r[75:72]];
		r[50:46] = r[50:46] ^ idx;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/lbc_round.sv
// One LBlock Feistel round, shared by encryption and decryption.
// Depends on lbc_pkg (lbc_f).
`default_nettype none

module lbc_round
	import lbc_pkg::*;
(
	input  wire logic [31:0] hi,      // half fed to F
	input  wire logic [31:0] lo,      // half mixed with F output
	input  wire logic [31:0] rk,      // round key
	input  wire logic        dec,     // 1: inverse round
	output logic      [31:0] result   // new half
);

	logic [31:0] f_out;
	logic [31:0] mix;

	// key add, S-boxes, permutation
	assign f_out = lbc_f(hi ^ rk);
	assign mix   = lo ^ (dec ? f_out : 32'd0);

	// encrypt: rotl8(lo) ^ F; decrypt: rotr8(lo ^ F)
	always_comb begin
		if (dec) begin
			result = {mix[7:0], mix[31:8]};
		end else begin
			result = {lo[23:0], lo[31:24]} ^ f_out;
		end
	end

endmodule

`default_nettype wire

>>> src/lblock_cipher_64_80_core.sv
// LBlock 64/80 cipher core top level: config, key store, sequencer, stream ports.
// Depends on lbc_pkg and lbc_round.
`default_nettype none

// LBlock block cipher, 64-bit block, 80-bit key, one round per clock.
// Write the key through the config port (index 0: key bits 63..0, index 1:
// key bits 79..64) while the core is idle. The first word after reset or after
// a key write first expands the round keys into an internal store, one key per
// cycle, and then fetches the first key. With the store valid, the first round
// key is fetched at the accepting edge. Each cycle makes one pass through the
// single round unit; the last pass holds until the output register is free.
// The core is ready again the cycle after the result is loaded. tuser[0]
// selects encrypt (0) or decrypt (1). The core takes one word at a time; a new
// word can be accepted while the previous result still waits in the output
// register.
module lblock_cipher_64_80_core
	import lbc_pkg::*;
#(
	parameter int unsigned ROUNDS = LBC_ROUNDS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write port
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_wdata,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [63:0] data_in
	input  wire logic [0:0]  s_axis_tuser,   // [0] cmd
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [63:0] m_axis_tdata    // [63:0] data_out
);

	localparam int unsigned CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(ROUNDS - 1);

	// state
	lbc_state_t       state_q, state_d;
	logic [CNT_W-1:0] rnd_q;
	logic             keys_ready_q;
	logic [63:0]      key_low_q;
	logic [15:0]      key_high_q;
	logic [79:0]      kreg_q;
	logic [31:0]      rk_mem [ROUNDS];
	logic [31:0]      rk_q;
	logic [31:0]      hi_q;
	logic [31:0]      lo_q;
	logic             cmd_q;
	logic             out_valid_q;
	logic [63:0]      out_data_q;

	// control
	logic             s_acc;
	logic             m_acc;
	logic             rnd_last;
	logic             out_free;
	logic             rd_en;
	logic [CNT_W-1:0] rd_addr;
	logic             exp_we;
	logic             step;
	logic             out_load;
	logic [4:0]       step_idx;
	logic [31:0]      round_out;

	assign s_acc    = s_axis_tvalid & s_axis_tready;
	assign m_acc    = out_valid_q & m_axis_tready;
	assign rnd_last = (rnd_q == LAST_IDX);
	assign out_free = ~out_valid_q | m_axis_tready;
	assign step_idx = 5'(rnd_q) + 5'd1;

	// config registers; any key write invalidates the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_we) begin
			case (lbc_reg_t'(cfg_index))
				REG_KEY_LOW:  key_low_q  <= cfg_wdata;
				REG_KEY_HIGH: key_high_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					state_d = keys_ready_q ? ST_ROUND : ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				if (rnd_last) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_last && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		rd_addr       = '0;
		exp_we        = 1'b0;
		step          = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				rd_en         = s_acc & keys_ready_q;
				rd_addr       = s_axis_tuser[0] ? LAST_IDX : '0;
			end
			ST_EXPAND: begin
				exp_we = 1'b1;
			end
			ST_PREP: begin
				rd_en   = 1'b1;
				rd_addr = cmd_q ? LAST_IDX : '0;
			end
			ST_ROUND: begin
				step     = ~rnd_last;
				out_load = rnd_last & out_free;
				rd_en    = ~rnd_last;
				rd_addr  = cmd_q ? (LAST_IDX - rnd_q - CNT_W'(1)) : (rnd_q + CNT_W'(1));
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rnd_q        <= '0;
			keys_ready_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_acc || (exp_we && rnd_last)) begin
				rnd_q <= '0;
			end else if (exp_we || step) begin
				rnd_q <= rnd_q + CNT_W'(1);
			end
			if (cfg_we) begin
				keys_ready_q <= 1'b0;
			end else if (exp_we && rnd_last) begin
				keys_ready_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// round key store and key schedule register
	always_ff @(posedge clk) begin
		if (s_acc) begin
			kreg_q <= {key_high_q, key_low_q};
		end else if (exp_we) begin
			kreg_q <= lbc_key_step(kreg_q, step_idx);
		end
		if (exp_we) begin
			rk_mem[rnd_q] <= kreg_q[79:48];
		end
		if (rd_en) begin
			rk_q <= rk_mem[rd_addr];
		end
	end

	// shared round unit
	lbc_round u_round (
		.hi     (hi_q),
		.lo     (lo_q),
		.rk     (rk_q),
		.dec    (cmd_q),
		.result (round_out)
	);

	// block halves and output register
	always_ff @(posedge clk) begin
		if (s_acc) begin
			hi_q  <= s_axis_tdata[63:32];
			lo_q  <= s_axis_tdata[31:0];
			cmd_q <= s_axis_tuser[0];
		end else if (step) begin
			hi_q <= round_out;
			lo_q <= hi_q;
		end
		if (out_load) begin
			out_data_q <= {hi_q, round_out};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// the store is only rebuilt while it is marked stale
	a_expand_stale: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXPAND |-> !keys_ready_q)
		else $error("key expansion running with keys marked ready");

	// a result is loaded only on the last round
	a_load_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (state_q == ST_ROUND) && rnd_last)
		else $error("result loaded before last round");

	// an accepted word always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> state_q != ST_IDLE)
		else $error("accepted word did not start");

	// a taken result is not repeated
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && !out_load |=> !out_valid_q)
		else $error("result delivered twice");

endmodule

`default_nettype wire

>>> dv/tb_lblock_cipher_64_80_core.sv
// Self-checking testbench for the LBlock 64/80 cipher core.
// Depends on lbc_pkg (round count and register indexes) and lblock_cipher_64_80_core.
`timescale 1ns / 100ps

module tb_lblock_cipher_64_80_core;
	import lbc_pkg::*;

	localparam int unsigned NUM_ROUNDS = LBC_ROUNDS;
	localparam bit CMD_ENC = 1'b0;
	localparam bit CMD_DEC = 1'b1;
	localparam int LONG_STALL = 400;
	localparam int IDLE_PCT = 34;

	// cipher tables: S0..S7 for F, S8/S9 for the key schedule
	localparam logic [3:0] CIPHER_SBOX [10][16] = '{
		'{4'd14, 4'd9,  4'd15, 4'd0,  4'd13, 4'd4,  4'd10, 4'd11,
		  4'd1,  4'd2,  4'd8,  4'd3,  4'd7,  4'd6,  4'd12, 4'd5},
		'{4'd4,  4'd11, 4'd14, 4'd9,  4'd15, 4'd13, 4'd0,  4'd10,
		  4'd7,  4'd12, 4'd5,  4'd6,  4'd2,  4'd8,  4'd1,  4'd3},
		'{4'd1,  4'd14, 4'd7,  4'd12, 4'd15, 4'd13, 4'd0,  4'd6,
		  4'd11, 4'd5,  4'd9,  4'd3,  4'd2,  4'd4,  4'd8,  4'd10},
		'{4'd7,  4'd6,  4'd8,  4'd11, 4'd0,  4'd15, 4'd3,  4'd14,
		  4'd9,  4'd10, 4'd12, 4'd13, 4'd5,  4'd2,  4'd4,  4'd1},
		'{4'd14, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd12, 4'd13,
		  4'd1,  4'd8,  4'd4,  4'd9,  4'd11, 4'd10, 4'd6,  4'd3},
		'{4'd2,  4'd13, 4'd11, 4'd12, 4'd15, 4'd14, 4'd0,  4'd9,
		  4'd7,  4'd10, 4'd6,  4'd3,  4'd1,  4'd8,  4'd4,  4'd5},
		'{4'd11, 4'd9,  4'd4,  4'd14, 4'd0,  4'd15, 4'd10, 4'd13,
		  4'd6,  4'd12, 4'd5,  4'd7,  4'd3,  4'd8,  4'd1,  4'd2},
		'{4'd13, 4'd10, 4'd15, 4'd0,  4'd14, 4'd4,  4'd9,  4'd11,
		  4'd2,  4'd1,  4'd8,  4'd3,  4'd7,  4'd5,  4'd12, 4'd6},
		'{4'd8,  4'd7,  4'd14, 4'd5,  4'd15, 4'd13, 4'd0,  4'd6,
		  4'd11, 4'd12, 4'd9,  4'd10, 4'd2,  4'd4,  4'd1,  4'd3},
		'{4'd11, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd9,  4'd13,
		  4'd4,  4'd8,  4'd1,  4'd12, 4'd14, 4'd10, 4'd3,  4'd6}
	};
	// nibble j after the permutation comes from S-box output nibble NIB_SRC[j]
	localparam int NIB_SRC [8] = '{1, 3, 0, 2, 5, 7, 4, 6};

	typedef struct packed {
		logic        cmd;
		logic [63:0] blk;
	} blk_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;    // [63:0] data_in
	logic [0:0]  s_axis_tuser = '0;    // [0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;         // [63:0] data_out

	lblock_cipher_64_80_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// words waiting to be sent, and results still owed by the core
	blk_req_t    send_q[$];
	logic [63:0] owed_blocks[$];
	int          queued_cnt = 0;
	int          accepted_cnt = 0;
	int          done_cnt = 0;
	int          err_cnt = 0;
	logic        in_taken = 1'b0;

	// knobs set by the stimulus process, plus the receiver's stall tracking
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	bit          stall_req = 1'b0;
	bit          stall_seen = 1'b0;
	int          stall_left = 0;

	// predictor copy of the key registers and the round key schedule
	logic [63:0] key_lo_m = '0;
	logic [15:0] key_hi_m = '0;
	logic [31:0] sched_keys [32];
	bit          sched_ok = 1'b0;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	function automatic logic [31:0] round_f(input logic [31:0] half, input logic [31:0] rk);
		logic [31:0] u;
		logic [31:0] s;
		logic [31:0] p;
		u = half ^ rk;
		for (int j = 0; j < 8; j++)
			s[4*j +: 4] = CIPHER_SBOX[j][u[4*j +: 4]];
		for (int j = 0; j < 8; j++)
			p[4*j +: 4] = s[4*NIB_SRC[j] +: 4];
		return p;
	endfunction

	// fill sched_keys from the current 80-bit key
	function automatic void expand_schedule();
		logic [79:0] k;
		k = {key_hi_m, key_lo_m};
		sched_keys[0] = k[79:48];
		for (int i = 1; i < NUM_ROUNDS; i++) begin
			k = {k[50:0], k[79:51]};
			k[79:76] = CIPHER_SBOX[9][k[79:76]];
			k[75:72] = CIPHER_SBOX[8][k[75:72]];
			k[50:46] = k[50:46] ^ 5'(i);
			sched_keys[i] = k[79:48];
		end
		sched_ok = 1'b1;
	endfunction

	function automatic logic [63:0] cipher_block(input logic cmd, input logic [63:0] blk);
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] x;
		logic [31:0] t;
		lo = blk[31:0];
		hi = blk[63:32];
		if (cmd == CMD_ENC) begin
			for (int r = 0; r < NUM_ROUNDS; r++) begin
				x = {lo[23:0], lo[31:24]} ^ round_f(hi, sched_keys[r]);
				if (r + 1 < NUM_ROUNDS) begin
					lo = hi;
					hi = x;
				end else begin
					lo = x;
				end
			end
		end else begin
			for (int r = NUM_ROUNDS; r > 0; r--) begin
				if (r < NUM_ROUNDS) begin
					t = lo;
					lo = hi;
					hi = t;
				end
				x = lo ^ round_f(hi, sched_keys[r-1]);
				lo = {x[7:0], x[31:8]};
			end
		end
		return {hi, lo};
	endfunction

	// sender: holds a word until taken, idles at random
	always @(negedge clk) begin : sender
		blk_req_t req;
		if (!s_axis_tvalid || in_taken) begin
			if (send_q.size() > 0 && (tx_calm || $urandom_range(99) >= IDLE_PCT)) begin
				req = send_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= req.blk;
				s_axis_tuser <= req.cmd;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure plus one long hold-off on request
	always @(negedge clk) begin
		if (stall_req != stall_seen) begin
			stall_seen = stall_req;
			stall_left = LONG_STALL;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor: track key writes, predict accepted words, check results
	always @(posedge clk) begin : monitor
		logic [63:0] want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_KEY_LOW)
					key_lo_m = cfg_wdata;
				else
					key_hi_m = cfg_wdata[15:0];
				sched_ok = 1'b0;
			end
			in_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				if (!sched_ok)
					expand_schedule();
				owed_blocks.push_back(cipher_block(s_axis_tuser[0], s_axis_tdata));
				accepted_cnt++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_blocks.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
				end else begin
					want = owed_blocks.pop_front();
					done_cnt++;
					if (m_axis_tdata !== want)
						report_mismatch($sformatf("data_out %h, want %h", m_axis_tdata, want));
				end
			end
		end
	end

	task automatic add_item(input logic cmd, input logic [63:0] blk);
		send_q.push_back('{cmd: cmd, blk: blk});
		queued_cnt++;
	endtask

	// block until all queued requests are answered
	task automatic wait_drained();
		while (done_cnt != queued_cnt)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_key(input lbc_reg_t idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// upper bits of a key_high write carry junk the core must drop
	function automatic logic [63:0] high_word(input logic [15:0] v);
		return {$urandom, 16'($urandom), v};
	endfunction

	function automatic logic [63:0] pick_block();
		int mode;
		mode = $urandom_range(99);
		if (mode < 75)
			return {$urandom, $urandom};
		else if (mode < 80)
			return '0;
		else if (mode < 85)
			return '1;
		else if (mode < 92)
			return 64'd1 << $urandom_range(63);
		else
			return ~(64'd1 << $urandom_range(63));
	endfunction

	// stimulus
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key (all zero), no write: first word must trigger expansion
		add_item(CMD_ENC, 64'h0);
		add_item(CMD_ENC, '1);
		add_item(CMD_DEC, 64'h0);
		add_item(CMD_DEC, '1);
		add_item(CMD_ENC, 64'h0123_4567_89AB_CDEF);
		add_item(CMD_DEC, 64'h0123_4567_89AB_CDEF);
		add_item(CMD_ENC, 64'h8000_0000_0000_0001);
		add_item(CMD_DEC, 64'h5555_AAAA_5555_AAAA);
		wait_drained();

		// all-ones key
		write_key(REG_KEY_LOW, '1);
		write_key(REG_KEY_HIGH, high_word(16'hFFFF));
		add_item(CMD_ENC, 64'h0);
		add_item(CMD_ENC, '1);
		add_item(CMD_DEC, 64'h0);
		add_item(CMD_DEC, '1);
		add_item(CMD_ENC, 64'hAAAA_5555_AAAA_5555);
		wait_drained();

		// only the high key register rewritten: schedule must still be rebuilt
		write_key(REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_0000);
		add_item(CMD_ENC, 64'h0);
		add_item(CMD_DEC, '1);
		add_item(CMD_ENC, 64'hFEDC_BA98_7654_3210);
		add_item(CMD_DEC, 64'hFEDC_BA98_7654_3210);
		wait_drained();

		// random phases, each with its own key
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				1: begin
					write_key(REG_KEY_LOW, '0);
					write_key(REG_KEY_HIGH, high_word(16'hFFFF));
				end
				3: write_key(REG_KEY_LOW, '1);
				6: begin
					write_key(REG_KEY_LOW, '0);
					write_key(REG_KEY_HIGH, high_word(16'h0000));
				end
				default: begin
					write_key(REG_KEY_LOW, {$urandom, $urandom});
					write_key(REG_KEY_HIGH, high_word(16'($urandom)));
				end
			endcase
			tx_calm = (ph == 2);
			rx_calm = (ph == 2);
			for (int n = 0; n < 210; n++) begin
				add_item(1'($urandom_range(1)), pick_block());
				// mid-phase pause until the core has answered everything
				if (ph == 5 && n == 100)
					wait_drained();
			end
			if (ph == 4) begin
				repeat (20) @(posedge clk);
				stall_req = ~stall_req;
			end
			wait_drained();
		end

		tx_calm = 1'b0;
		rx_calm = 1'b0;
		repeat (80) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS lblock_cipher_64_80_core");
		else
			$display("FAIL lblock_cipher_64_80_core");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("FAIL lblock_cipher_64_80_core");
		$finish;
	end

endmodule

>>> files.f
src/lbc_pkg.sv
src/lbc_round.sv
src/lblock_cipher_64_80_core.sv
dv/tb_lblock_cipher_64_80_core.sv
